// ===== rtl/ffib_pkg.sv =====
// Shared widths, codes and beat types for the first-fit interval booking unit.
package ffib_pkg;

  localparam int unsigned DAY_W    = 16;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned CFG_W    = 3;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned RESOURCES_DEF = 4;
  localparam int unsigned SLOTS_DEF     = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_BOOKED   = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } req_t;

  // Token that ripples down the cell row during the pick phase.
  typedef struct packed {
    logic             valid;
    logic             booked;
    logic             full_seen;
    logic [IDX_W-1:0] idx;
  } tok_t;

endpackage

// ===== rtl/ffib_cell.sv =====
// One resource: its reservation table, fill count, overlap check and token stage.
module ffib_cell #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned INDEX  = 0,
  parameter int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffib_pkg::req_t      req_i,
  input  logic                clr_i,
  input  logic                rd_en_i,
  input  logic [SLOT_W-1:0]   rd_addr_i,
  input  logic                active_i,
  input  ffib_pkg::tok_t      tok_i,
  output ffib_pkg::tok_t      tok_o
);
  import ffib_pkg::*;

  localparam int unsigned FILL_W = $clog2(SLOTS + 1);

  req_t              mem [SLOTS];
  req_t              rdata_q;
  logic              rd_en_q;
  logic [SLOT_W-1:0] addr_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              clash_q, clash_d;
  tok_t              tok_q, tok_d;
  logic              full, hit, take;

  assign full = (fill_q == FILL_W'(SLOTS));

  // Only slots below the fill count have ever been written.
  assign hit = rd_en_q && (FILL_W'(addr_q) < fill_q)
            && (rdata_q.day == req_i.day)
            && (rdata_q.start_time < req_i.end_time)
            && (rdata_q.end_time > req_i.start_time);

  assign take = tok_i.valid && !tok_i.booked && active_i && !clash_q && !full;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.booked && active_i && !clash_q) begin
      if (full) begin
        tok_d.full_seen = 1'b1;
      end else begin
        tok_d.booked = 1'b1;
        tok_d.idx    = IDX_W'(INDEX);
      end
    end
  end

  always_comb begin
    clash_d = clash_q;
    if (clr_i) begin
      clash_d = 1'b0;
    end else if (hit) begin
      clash_d = 1'b1;
    end
    fill_d = take ? fill_q + FILL_W'(1) : fill_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_en_q <= 1'b0;
      clash_q <= 1'b0;
      fill_q  <= '0;
      tok_q   <= '0;
    end else begin
      rd_en_q <= rd_en_i;
      clash_q <= clash_d;
      fill_q  <= fill_d;
      tok_q   <= tok_d;
    end
  end

  // Table port: one read, one append.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
    addr_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mem[fill_q[SLOT_W-1:0]] <= req_i;
    end
  end

  assign tok_o = tok_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(SLOTS))
    else $error("fill count beyond table depth");

  a_take_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (fill_q == $past(fill_q) + FILL_W'(1)))
    else $error("booking did not advance fill count");

  a_clear_drops_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i |=> !clash_q)
    else $error("clash flag survived a new request");

endmodule

// ===== rtl/first_fit_interval_booking_unit.sv =====
// Top level of the first-fit interval booking unit: control, config register, cell row.
//
//  channel   | signals                                            | handshake
//  ----------+----------------------------------------------------+--------------------------
//  request   | start, busy, day_i, start_time_i, end_time_i       | beat when start && !busy
//  result    | done_o, status_o, resource_index_o                 | one-cycle strobe, no stall
//  config    | cfg_valid_i, cfg_ready_o, cfg_resources_in_use_i   | beat when valid && ready
//
// One request keeps busy high through the scan, drain and pick states; done_o
// strobes in the cycle busy drops. The scan walks the tables (one read per slot on each
// resource's table) and the pick ripples the token down the cell row.
// Reset clears all fill counts, so every table reads empty; the register returns to 4.
// Results cannot be stalled; a new request may start in the same cycle as done_o.
module first_fit_interval_booking_unit #(
  parameter int unsigned RESOURCES          = ffib_pkg::RESOURCES_DEF,
  parameter int unsigned SLOTS_PER_RESOURCE = ffib_pkg::SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [ffib_pkg::DAY_W-1:0]     day_i,
  input  logic [ffib_pkg::TIME_W-1:0]    start_time_i,
  input  logic [ffib_pkg::TIME_W-1:0]    end_time_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ffib_pkg::CFG_W-1:0]     cfg_resources_in_use_i,
  output logic                           done_o,
  output logic [ffib_pkg::STATUS_W-1:0]  status_o,
  output logic [ffib_pkg::IDX_W-1:0]     resource_index_o
);
  import ffib_pkg::*;

  localparam int unsigned SLOT_W = (SLOTS_PER_RESOURCE > 1) ? $clog2(SLOTS_PER_RESOURCE) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PICK
  } state_e;

  state_e            state_q;
  logic [SLOT_W-1:0] slot_q;
  logic              inj_q;
  logic [CFG_W-1:0]  cfg_q;
  req_t              req_q;
  logic              done_q;
  status_e           status_q;
  logic [IDX_W-1:0]  idx_q;

  logic              accept;
  logic [RESOURCES-1:0] active;
  tok_t              tok [RESOURCES+1];

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  // Hold off register writes while a request is in flight.
  assign cfg_ready_o = !busy;

  // Inject the token at cell 0 for one cycle once every overlap check has settled.
  assign tok[0] = '{valid: inj_q, booked: 1'b0, full_seen: 1'b0, idx: '0};

  for (genvar g = 0; g < RESOURCES; g++) begin : g_cell
    // Resources at or above the register value are never booked; the row saturates.
    assign active[g] = (32'(cfg_q) > 32'(g));

    ffib_cell #(
      .SLOTS  (SLOTS_PER_RESOURCE),
      .INDEX  (g),
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .req_i     (req_q),
      .clr_i     (accept),
      .rd_en_i   (state_q == S_SCAN),
      .rd_addr_i (slot_q),
      .active_i  (active[g]),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      slot_q   <= '0;
      inj_q    <= 1'b0;
      cfg_q    <= CFG_RESET;
      req_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_BOOKED;
      idx_q    <= '0;
    end else begin
      done_q <= 1'b0;
      inj_q  <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_resources_in_use_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q   <= '{day: day_i, start_time: start_time_i, end_time: end_time_i};
            slot_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Walk every slot; each cell compares the beat read in the previous cycle.
          if (slot_q == SLOT_W'(SLOTS_PER_RESOURCE - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            slot_q <= slot_q + SLOT_W'(1);
          end
        end
        S_DRAIN: begin
          // Last compare lands this cycle; launch the token next.
          inj_q   <= 1'b1;
          state_q <= S_PICK;
        end
        S_PICK: begin
          if (tok[RESOURCES].valid) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
            if (tok[RESOURCES].booked) begin
              status_q <= ST_BOOKED;
              idx_q    <= tok[RESOURCES].idx;
            end else begin
              status_q <= tok[RESOURCES].full_seen ? ST_FULL : ST_CONFLICT;
              idx_q    <= '0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign resource_index_o = idx_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o)
    else $error("accepted request did not raise busy");

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_BOOKED)) |-> (resource_index_o == '0))
    else $error("index nonzero on unbooked result");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the first-fit interval booking unit.
module testbench;
  import ffib_pkg::*;

  localparam int unsigned RES             = RESOURCES_DEF;
  localparam int unsigned SLOTS           = SLOTS_DEF;
  // One request holds busy for the slot walk, the drain state and the token ripple.
  localparam int unsigned BOOKING_LATENCY = SLOTS + RES + 2;
  localparam int unsigned DRAIN_CYCLES    = 4 * BOOKING_LATENCY;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned PHASES          = 11;
  localparam int unsigned ITEMS_PER_PHASE = 165;
  // Register setting per random phase, phase 0 in the rightmost element.
  localparam logic [PHASES-1:0][CFG_W-1:0] PHASE_SETTINGS =
    {3'd4, 3'd7, 3'd2, 3'd5, 3'd1, 3'd6, 3'd4, 3'd0, 3'd3, 3'd2, 3'd1};

  typedef struct {
    status_e          status;
    logic [IDX_W-1:0] rsrc;
  } booking_outcome_t;

  // DUT ports; every input holds a known value from time zero.
  logic                clk_i                  = 1'b0;
  logic                rst_ni                 = 1'b0;
  logic                start                  = 1'b0;
  logic                busy;
  logic [DAY_W-1:0]    day_i                  = '0;
  logic [TIME_W-1:0]   start_time_i           = '0;
  logic [TIME_W-1:0]   end_time_i             = '0;
  logic                cfg_valid_i            = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_resources_in_use_i = '0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [IDX_W-1:0]    resource_index_o;

  // Booking tables as the block should hold them.
  req_t             booked_slots [RES][SLOTS];
  bit               slot_used    [RES][SLOTS];
  int unsigned      slot_fill    [RES];
  logic [CFG_W-1:0] resources_in_use_q = CFG_RESET;
  req_t             booked_log [$];

  booking_outcome_t pending_outcomes [$];
  booking_outcome_t oldest_outcome;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 3;
  bit          request_raised = 1'b0;

  first_fit_interval_booking_unit #(
    .RESOURCES          (RES),
    .SLOTS_PER_RESOURCE (SLOTS)
  ) dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .start                  (start),
    .busy                   (busy),
    .day_i                  (day_i),
    .start_time_i           (start_time_i),
    .end_time_i             (end_time_i),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_resources_in_use_i (cfg_resources_in_use_i),
    .done_o                 (done_o),
    .status_o               (status_o),
    .resource_index_o       (resource_index_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // First-fit pick: scan resources from zero, skip any with a same-day entry
  // that overlaps [s, e), skip full tables (noting them), book the first left.
  function automatic void predict_booking(input logic [DAY_W-1:0] d,
                                          input logic [TIME_W-1:0] s,
                                          input logic [TIME_W-1:0] e,
                                          output booking_outcome_t outcome);
    int unsigned scan;
    bit          clash;
    bit          full_seen;
    req_t        entry;
    scan      = (resources_in_use_q > RES) ? RES : resources_in_use_q;
    full_seen = 1'b0;
    outcome.status = ST_CONFLICT;
    outcome.rsrc   = '0;
    entry.day        = d;
    entry.start_time = s;
    entry.end_time   = e;
    for (int r = 0; r < scan; r++) begin
      clash = 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        if (slot_used[r][k] && booked_slots[r][k].day == d &&
            booked_slots[r][k].start_time < e && booked_slots[r][k].end_time > s) begin
          clash = 1'b1;
        end
      end
      if (clash) continue;
      if (slot_fill[r] >= SLOTS) begin
        full_seen = 1'b1;
        continue;
      end
      booked_slots[r][slot_fill[r]] = entry;
      slot_used[r][slot_fill[r]]    = 1'b1;
      slot_fill[r]++;
      booked_log = {booked_log, entry};
      outcome.status = ST_BOOKED;
      outcome.rsrc   = IDX_W'(r);
      return;
    end
    if (full_seen) outcome.status = ST_FULL;
  endfunction

  // Result checker: every strobe must match the oldest expected outcome.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status %0d index %0d",
                                  status_o, resource_index_o));
      end else begin
        oldest_outcome = pending_outcomes.pop_front();
        if (status_o !== oldest_outcome.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    status_o, oldest_outcome.status));
        if (resource_index_o !== oldest_outcome.rsrc)
          report_mismatch($sformatf("resource_index %0d, expected %0d",
                                    resource_index_o, oldest_outcome.rsrc));
      end
    end
  end

  // Send one request beat. Start stays high across a burst so back-to-back
  // beats land the cycle busy drops; drop it between bursts for a random gap.
  task automatic send_booking(input logic [DAY_W-1:0] d, input logic [TIME_W-1:0] s,
                              input logic [TIME_W-1:0] e);
    booking_outcome_t outcome;
    day_i        <= d;
    start_time_i <= s;
    end_time_i   <= e;
    if (!request_raised) begin
      start          <= 1'b1;
      request_raised  = 1'b1;
    end
    do @(posedge clk_i); while (busy);
    predict_booking(d, s, e, outcome);
    pending_outcomes = {pending_outcomes, outcome};
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start          <= 1'b0;
      request_raised  = 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      // Mostly short bursts, now and then a long stretch with no gaps.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
    end
  endtask

  // Drop start and wait until every outcome is back and the block is idle.
  task automatic settle_block();
    if (request_raised) begin
      start          <= 1'b0;
      request_raised  = 1'b0;
    end
    do @(posedge clk_i); while (pending_outcomes.size() != 0 || busy);
  endtask

  task automatic write_resources_in_use(input logic [CFG_W-1:0] value);
    settle_block();
    cfg_valid_i            <= 1'b1;
    cfg_resources_in_use_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i        <= 1'b0;
    resources_in_use_q  = value;
  endtask

  // Random request: mostly crowded days with short windows so conflicts are
  // common, plus full-range fields, empty or reversed intervals, and near
  // copies of earlier bookings to hit the strict compare boundaries.
  function automatic void make_request(output logic [DAY_W-1:0] d,
                                       output logic [TIME_W-1:0] s,
                                       output logic [TIME_W-1:0] e);
    int unsigned roll;
    req_t        prior;
    roll = $urandom_range(0, 99);
    if (roll >= 80 && booked_log.size() == 0) roll = 0;
    if (roll < 55) begin
      d = DAY_W'($urandom_range(0, 3));
      s = TIME_W'($urandom_range(0, 60));
      e = s + TIME_W'($urandom_range(1, 12));
    end else if (roll < 70) begin
      d = DAY_W'($urandom);
      s = TIME_W'($urandom);
      e = TIME_W'($urandom);
    end else if (roll < 80) begin
      d = DAY_W'($urandom_range(0, 3));
      s = TIME_W'($urandom_range(0, 64));
      e = s - TIME_W'($urandom_range(0, 5));
    end else begin
      prior = booked_log[$urandom_range(0, booked_log.size() - 1)];
      d = prior.day;
      s = prior.start_time + TIME_W'($urandom_range(0, 2)) - TIME_W'(1);
      e = prior.end_time + TIME_W'($urandom_range(0, 2)) - TIME_W'(1);
    end
  endfunction

  // Overlap rules at the reset setting: repeat, touching, straddling,
  // reversed, empty and all-ones extremes.
  task automatic test_overlap_rules();
    send_booking(16'h0000, 16'd0, 16'd10);
    send_booking(16'h0000, 16'd0, 16'd10);
    send_booking(16'h0000, 16'd10, 16'd20);
    send_booking(16'h0000, 16'd9, 16'd11);
    send_booking(16'h0000, 16'd20, 16'd5);
    send_booking(16'h0000, 16'd7, 16'd7);
    send_booking(16'hFFFF, 16'h0000, 16'hFFFF);
    send_booking(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_booking(16'hFFFF, 16'hFFFF, 16'h0000);
  endtask

  // Zero resources scans nothing; settings above the resource count saturate.
  task automatic test_resource_count_extremes();
    write_resources_in_use(3'd0);
    send_booking(16'h5555, 16'h00FF, 16'hFF00);
    send_booking(16'hAAAA, 16'h0000, 16'h0001);
    write_resources_in_use(3'd7);
    repeat (RES + 1) send_booking(16'h0100, 16'd300, 16'd400);
    write_resources_in_use(3'd5);
    send_booking(16'h0100, 16'd350, 16'd360);
    write_resources_in_use(3'd6);
    send_booking(16'h0100, 16'd400, 16'd401);
  endtask

  // Random traffic over a sweep of settings; tables fill and stay full,
  // so the later phases work the full-table and conflict outcomes.
  task automatic test_random_traffic();
    logic [DAY_W-1:0]  d;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    for (int p = 0; p < PHASES; p++) begin
      write_resources_in_use(PHASE_SETTINGS[p]);
      repeat (ITEMS_PER_PHASE) begin
        make_request(d, s, e);
        send_booking(d, s, e);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_overlap_rules();
    test_resource_count_extremes();
    test_random_traffic();
    settle_block();
    // Hold a while longer so a stray late strobe is still caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
